// File: hw/rtl/ltq_pkg.sv
// Shared types and constants for the lease table.
package ltq_pkg;

	localparam int ID_W     = 32;
	localparam int TEN_W    = 16;
	localparam int TIME_W   = 48;
	localparam int GEN_W    = 48;
	localparam int LEASE_W  = 32;
	localparam int LIM_W    = 7;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 4;
	localparam int ECNT_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	// counters sized for the largest supported table
	localparam int MAX_DEPTH = 1024;
	localparam int CNT_W    = $clog2(MAX_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_DEV = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EXPIRE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd4;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 4'd0;
	localparam logic [STAT_W-1:0] ST_REFRESHED = 4'd1;
	localparam logic [STAT_W-1:0] ST_INVALID   = 4'd2;
	localparam logic [STAT_W-1:0] ST_CONFLICT  = 4'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 4'd4;
	localparam logic [STAT_W-1:0] ST_DEVICE    = 4'd5;
	localparam logic [STAT_W-1:0] ST_TENANT    = 4'd6;
	localparam logic [STAT_W-1:0] ST_DONE      = 4'd7;
	localparam logic [STAT_W-1:0] ST_FOUND     = 4'd8;
	localparam logic [STAT_W-1:0] ST_ABSENT    = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEV_LIM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEN_LIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_LEASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEASE = 3'd4;

	typedef enum logic [2:0] {
		M_HBFIND = 3'd0,
		M_LOOKUP = 3'd1,
		M_REMOVE = 3'd2,
		M_DEVDEL = 3'd3,
		M_EXPDEL = 3'd4,
		M_COUNT  = 3'd5,
		M_INSERT = 3'd6,
		M_ERASE  = 3'd7
	} mode_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ID_W-1:0]    device;
		logic [ID_W-1:0]    endpoint;
		logic [TEN_W-1:0]   tenant_id;
		logic [LEASE_W-1:0] lease_ms;
		logic [TIME_W-1:0]  time_now;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [GEN_W-1:0]   generation;
		logic [TIME_W-1:0]  expiry_time;
		logic [ECNT_W-1:0]  entry_count;
		logic [TEN_W-1:0]   owner_tenant;
	} rsp_t;

	// word handed from cell to cell
	typedef struct packed {
		logic              vld;
		mode_t             mode;
		logic [ID_W-1:0]   dev;
		logic [ID_W-1:0]   ep;
		logic [TEN_W-1:0]  ten;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] expiry;
		logic [GEN_W-1:0]  gen;
		logic              erase_vld;
		logic [TEN_W-1:0]  erase_ten;
		logic [ID_W-1:0]   erase_dev;
		logic              hit;
		logic              live;
		logic [TEN_W-1:0]  hit_ten;
		logic [ID_W-1:0]   hit_dev;
		logic [GEN_W-1:0]  hit_gen;
		logic [TIME_W-1:0] hit_exp;
		logic [CNT_W-1:0]  live_cnt;
		logic [CNT_W-1:0]  dev_cnt;
		logic [CNT_W-1:0]  ten_cnt;
		logic              ten_dev;
		logic              slot_ok;
		logic              pslot_ok;
		logic              ins_ent;
		logic              ins_pair;
	} tok_t;

endpackage

// File: hw/rtl/ltq_cell.sv
// One table slot plus one tenant-device pair slot; acts on the passing word.
module ltq_cell
	import ltq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_i,
	output tok_t tok_o
);

	logic              v_q, pv_q;
	logic [ID_W-1:0]   dev_q, ep_q, pdev_q;
	logic [TEN_W-1:0]  ten_q, pten_q;
	logic [GEN_W-1:0]  gen_q;
	logic [TIME_W-1:0] exp_q;
	tok_t              tok_q;

	tok_t t;
	logic v_d, pv_d, ent_wr, ref_wr, pair_wr;
	logic key_hit, alive, erase_hit, pv_eff;

	always_comb begin
		t = tok_i;
		v_d = v_q;
		pv_d = pv_q;
		ent_wr = 1'b0;
		ref_wr = 1'b0;
		pair_wr = 1'b0;
		key_hit = v_q && dev_q == tok_i.dev && ep_q == tok_i.ep;
		alive = exp_q > tok_i.now;
		erase_hit = tok_i.vld && tok_i.erase_vld && pv_q && pten_q == tok_i.erase_ten
			&& pdev_q == tok_i.erase_dev;
		pv_eff = pv_q && !erase_hit;
		if (tok_i.vld) begin
			if (erase_hit) begin
				pv_d = 1'b0;
				t.erase_vld = 1'b0;
			end
			case (tok_i.mode)
				M_HBFIND: begin
					if (key_hit) begin
						t.hit = 1'b1;
						t.live = alive;
						t.hit_ten = ten_q;
						t.hit_dev = dev_q;
						if (!alive) begin
							v_d = 1'b0;
						end else if (ten_q == tok_i.ten) begin
							ref_wr = 1'b1;
						end
					end
				end
				M_LOOKUP: begin
					if (key_hit) begin
						t.hit = 1'b1;
						t.live = alive;
						t.hit_ten = ten_q;
						t.hit_gen = gen_q;
						t.hit_exp = exp_q;
					end
				end
				M_REMOVE: begin
					if (key_hit) begin
						v_d = 1'b0;
						t.hit = 1'b1;
						t.hit_ten = ten_q;
						t.hit_dev = dev_q;
					end
				end
				M_DEVDEL, M_EXPDEL: begin
					if (!tok_i.hit && v_q && ((tok_i.mode == M_DEVDEL && dev_q == tok_i.dev)
							|| (tok_i.mode == M_EXPDEL && !alive))) begin
						v_d = 1'b0;
						t.hit = 1'b1;
						t.hit_ten = ten_q;
						t.hit_dev = dev_q;
					end
				end
				M_COUNT: begin
					if (v_q) begin
						t.live_cnt = tok_i.live_cnt + 1'b1;
						if (dev_q == tok_i.dev) begin
							t.dev_cnt = tok_i.dev_cnt + 1'b1;
						end
					end else begin
						t.slot_ok = 1'b1;
					end
					if (pv_eff) begin
						if (pten_q == tok_i.ten) begin
							t.ten_cnt = tok_i.ten_cnt + 1'b1;
							if (pdev_q == tok_i.dev) begin
								t.ten_dev = 1'b1;
							end
						end
					end else begin
						t.pslot_ok = 1'b1;
					end
				end
				M_INSERT: begin
					// first free slot takes the entry, first free pair slot the pair
					if (tok_i.ins_ent && !v_q) begin
						v_d = 1'b1;
						ent_wr = 1'b1;
						t.ins_ent = 1'b0;
					end
					if (tok_i.ins_pair && !pv_q) begin
						pv_d = 1'b1;
						pair_wr = 1'b1;
						t.ins_pair = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
			pv_q <= 1'b0;
			tok_q <= '0;
		end else begin
			v_q <= v_d;
			pv_q <= pv_d;
			tok_q <= t;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_wr) begin
			dev_q <= tok_i.dev;
			ep_q <= tok_i.ep;
			ten_q <= tok_i.ten;
		end
		if (ent_wr || ref_wr) begin
			exp_q <= tok_i.expiry;
			gen_q <= tok_i.gen;
		end
		if (pair_wr) begin
			pten_q <= tok_i.ten;
			pdev_q <= tok_i.dev;
		end
	end

	assign tok_o = tok_q;

endmodule

// File: hw/rtl/lease_table_with_quotas.sv
// Lease table top: command sequencer driving a chain of table cells.
// A pass sends one word down the chain, through the input register and each cell's register.
// Heartbeat: 1 to 3 passes; lookup: 1; remove: 1 or 2; remove device and
// expire: k+1 passes for k entries dropped. Invalid commands answer in the cycle after start.
// One command at a time; the result strobe (done) lasts one cycle and cannot stall.
// Reset empties the table, loads register defaults and sets the generation to one.
module lease_table_with_quotas
	import ltq_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WAIT = 2'b10
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [TIME_W-1:0]  expiry_q;
	logic [GEN_W-1:0]   next_gen_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LIM_W-1:0]   cap_q, dev_lim_q, ten_lim_q;
	logic [LEASE_W-1:0] def_lease_q, max_lease_q;
	tok_t               tok_in_q;
	logic               done_q;
	rsp_t               rsp_q;

	tok_t chain [TABLE_DEPTH+1];
	tok_t tail;

	assign chain[0] = tok_in_q;
	assign tail = chain[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ltq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (chain[i]),
			.tok_o (chain[i+1])
		);
	end

	function automatic tok_t mk_tok(input mode_t m, input req_t r, input logic [TIME_W-1:0] ex,
			input logic [GEN_W-1:0] g, input logic ev, input logic [TEN_W-1:0] et,
			input logic [ID_W-1:0] ed);
		tok_t k;
		k = '0;
		k.vld = 1'b1;
		k.mode = m;
		k.dev = r.device;
		k.ep = r.endpoint;
		k.ten = r.tenant_id;
		k.now = r.time_now;
		k.expiry = ex;
		k.gen = g;
		k.erase_vld = ev;
		k.erase_ten = et;
		k.erase_dev = ed;
		return k;
	endfunction

	logic               accept;
	logic [LEASE_W-1:0] dur;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  expiry_new;
	logic               hb_bad;
	logic [CNT_W-1:0]   cnt_inc;

	assign accept = start && (state_q == S_IDLE);
	assign dur = (req.lease_ms == '0) ? def_lease_q : req.lease_ms;
	assign sum = {1'b0, req.time_now} + {{(TIME_W+1-LEASE_W){1'b0}}, dur};
	// saturate at the top of the time range
	assign expiry_new = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	assign hb_bad = req.device == '0 || req.endpoint == '0 || req.lease_ms > max_lease_q;
	assign cnt_inc = cnt_q + 1'b1;

	state_t           state_d;
	tok_t             tok_d;
	logic             done_d;
	rsp_t             rsp_d;
	logic [GEN_W-1:0] gen_d;
	logic [CNT_W-1:0] cnt_d;
	logic             full_c, dev_c, ten_c;

	always_comb begin
		state_d = state_q;
		tok_d = tok_in_q;
		tok_d.vld = 1'b0;
		done_d = 1'b0;
		rsp_d = '0;
		gen_d = next_gen_q;
		cnt_d = cnt_q;
		full_c = ({{(CNT_W-LIM_W){1'b0}}, cap_q} <= tail.live_cnt) || !tail.slot_ok;
		dev_c = tail.dev_cnt != '0 && tail.dev_cnt >= {{(CNT_W-LIM_W){1'b0}}, dev_lim_q};
		ten_c = tail.ten_cnt != '0 && !tail.ten_dev
			&& tail.ten_cnt >= {{(CNT_W-LIM_W){1'b0}}, ten_lim_q};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cnt_d = '0;
					state_d = S_WAIT;
					case (req.cmd)
						CMD_HEARTBEAT: begin
							if (hb_bad) begin
								state_d = S_IDLE;
								done_d = 1'b1;
								rsp_d.status = ST_INVALID;
							end else begin
								tok_d = mk_tok(M_HBFIND, req, expiry_new, next_gen_q, 1'b0,
									'0, '0);
							end
						end
						CMD_REMOVE: tok_d = mk_tok(M_REMOVE, req, expiry_new, next_gen_q, 1'b0,
							'0, '0);
						CMD_REMOVE_DEV: tok_d = mk_tok(M_DEVDEL, req, expiry_new, next_gen_q,
							1'b0, '0, '0);
						CMD_EXPIRE: tok_d = mk_tok(M_EXPDEL, req, expiry_new, next_gen_q, 1'b0,
							'0, '0);
						CMD_LOOKUP: tok_d = mk_tok(M_LOOKUP, req, expiry_new, next_gen_q, 1'b0,
							'0, '0);
						default: begin
							state_d = S_IDLE;
							done_d = 1'b1;
							rsp_d.status = ST_INVALID;
						end
					endcase
				end
			end
			S_WAIT: begin
				if (tail.vld) begin
					state_d = S_IDLE;
					done_d = 1'b1;
					rsp_d.status = ST_DONE;
					case (tail.mode)
						M_HBFIND: begin
							if (tail.hit && tail.live) begin
								if (tail.hit_ten == req_q.tenant_id) begin
									rsp_d.status = ST_REFRESHED;
									rsp_d.generation = next_gen_q;
									rsp_d.expiry_time = expiry_q;
									gen_d = next_gen_q + 1'b1;
								end else begin
									rsp_d.status = ST_CONFLICT;
								end
							end else begin
								// no live lease found; a hit that had expired was dropped and its pair goes in the count pass
								state_d = S_WAIT;
								done_d = 1'b0;
								tok_d = mk_tok(M_COUNT, req_q, expiry_q, next_gen_q, tail.hit,
									tail.hit_ten, tail.hit_dev);
							end
						end
						M_COUNT: begin
							if (full_c) begin
								rsp_d.status = ST_FULL;
							end else if (dev_c) begin
								rsp_d.status = ST_DEVICE;
							end else if (ten_c) begin
								rsp_d.status = ST_TENANT;
							end else begin
								state_d = S_WAIT;
								done_d = 1'b0;
								tok_d = mk_tok(M_INSERT, req_q, expiry_q, next_gen_q, 1'b0,
									'0, '0);
								tok_d.ins_ent = 1'b1;
								tok_d.ins_pair = !tail.ten_dev;
							end
						end
						M_INSERT: begin
							rsp_d.status = ST_INSERTED;
							rsp_d.generation = next_gen_q;
							rsp_d.expiry_time = expiry_q;
							gen_d = next_gen_q + 1'b1;
						end
						M_LOOKUP: begin
							if (tail.hit && tail.live) begin
								rsp_d.status = ST_FOUND;
								rsp_d.generation = tail.hit_gen;
								rsp_d.expiry_time = tail.hit_exp;
								rsp_d.owner_tenant = tail.hit_ten;
							end else begin
								rsp_d.status = ST_ABSENT;
							end
						end
						M_REMOVE: begin
							if (tail.hit) begin
								state_d = S_WAIT;
								done_d = 1'b0;
								cnt_d = cnt_inc;
								tok_d = mk_tok(M_ERASE, req_q, expiry_q, next_gen_q, 1'b1,
									tail.hit_ten, tail.hit_dev);
							end
						end
						M_DEVDEL, M_EXPDEL: begin
							// each pass after the first erases the previous drop's pair; each pass finds the next drop
							if (tail.hit) begin
								state_d = S_WAIT;
								done_d = 1'b0;
								cnt_d = cnt_inc;
								tok_d = mk_tok(tail.mode, req_q, expiry_q, next_gen_q, 1'b1,
									tail.hit_ten, tail.hit_dev);
							end else begin
								rsp_d.entry_count = cnt_q[ECNT_W-1:0];
							end
						end
						M_ERASE: rsp_d.entry_count = cnt_q[ECNT_W-1:0];
						default: begin
						end
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tok_in_q <= '0;
			done_q <= 1'b0;
			next_gen_q <= {{(GEN_W-1){1'b0}}, 1'b1};
			cnt_q <= '0;
			cap_q <= 7'd64;
			dev_lim_q <= 7'd8;
			ten_lim_q <= 7'd16;
			def_lease_q <= 32'd30000;
			max_lease_q <= 32'd300000;
		end else begin
			state_q <= state_d;
			tok_in_q <= tok_d;
			done_q <= done_d;
			next_gen_q <= gen_d;
			cnt_q <= cnt_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_CAPACITY:  cap_q <= cfg_wdata[LIM_W-1:0];
					REG_DEV_LIM:   dev_lim_q <= cfg_wdata[LIM_W-1:0];
					REG_TEN_LIM:   ten_lim_q <= cfg_wdata[LIM_W-1:0];
					REG_DEF_LEASE: def_lease_q <= cfg_wdata[LEASE_W-1:0];
					REG_MAX_LEASE: max_lease_q <= cfg_wdata[LEASE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			expiry_q <= expiry_new;
		end
		rsp_q <= rsp_d;
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp = rsp_q;

endmodule
